// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is active.
`define PST_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define PST_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pst_pkg.sv
package pst_pkg;

  localparam int SYM_W = 8;
  localparam int WIN_W = 3;
  localparam int MAX_PRED = 2 ** WIN_W;
  localparam int OUT_CNT_W = 24;
  localparam int MAX_CNT_W = 32;

  localparam int NUM_PREDICTORS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 24;

  typedef struct packed {
    logic             first_sample;
    logic             last_sample;
    logic [SYM_W-1:0] sample;
    logic [SYM_W-1:0] pred_0;
    logic [SYM_W-1:0] pred_1;
    logic [SYM_W-1:0] pred_2;
    logic [SYM_W-1:0] pred_3;
    logic [SYM_W-1:0] pred_4;
    logic [SYM_W-1:0] pred_5;
    logic [SYM_W-1:0] pred_6;
    logic [SYM_W-1:0] pred_7;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]     winner_index;
    logic [OUT_CNT_W-1:0] correct_count;
    logic [OUT_CNT_W-1:0] longest_run;
    logic [OUT_CNT_W-1:0] current_run;
    logic                 done_res;
  } out_item_t;

endpackage

// File: rtl/core/pst_winner_sel.sv
module pst_winner_sel #(
  parameter int NUM_PREDICTORS = pst_pkg::NUM_PREDICTORS_DEF,
  parameter int COUNT_WIDTH = pst_pkg::COUNT_WIDTH_DEF
) (
  input  logic [NUM_PREDICTORS-1:0]   match,
  input  logic [COUNT_WIDTH-1:0]      scores [NUM_PREDICTORS],
  input  logic [pst_pkg::WIN_W-1:0]   winner,
  output logic [COUNT_WIDTH-1:0]      scores_next [NUM_PREDICTORS],
  output logic [pst_pkg::WIN_W-1:0]   winner_next
);

  // ge[i][j]: new score of i is at least the score of j as seen when i is visited
  logic [pst_pkg::MAX_PRED-1:0] ge [NUM_PREDICTORS];

  always_comb begin
    for (int i = 0; i < NUM_PREDICTORS; i++) begin
      if (match[i] && (scores[i] != '1)) begin
        scores_next[i] = scores[i] + 1'b1;
      end else begin
        scores_next[i] = scores[i];
      end
    end
  end

  // All compares in parallel: entries already visited carry their new score.
  always_comb begin
    for (int i = 0; i < NUM_PREDICTORS; i++) begin
      ge[i] = '0;
      for (int j = 0; j < NUM_PREDICTORS; j++) begin
        if (j < i) begin
          ge[i][j] = scores_next[i] >= scores_next[j];
        end else begin
          ge[i][j] = scores_next[i] >= scores[j];
        end
      end
    end
  end

  // Narrow ordered select over the winner index.
  always_comb begin
    winner_next = winner;
    for (int i = 0; i < NUM_PREDICTORS; i++) begin
      if (match[i] && ge[i][winner_next]) begin
        winner_next = pst_pkg::WIN_W'(i);
      end
    end
  end

endmodule

// File: rtl/core/predictor_scoreboard_tracker.sv
// Multi-predictor scoreboard and run tracker.
//
// Input channel (item_valid / item_ready / item): one noise sample plus the
// prediction of every subpredictor. first_sample clears the scores, the
// winner and all counters before the sample is scored; last_sample is only
// copied to done_res of the matching result.
// Output channel (result_valid / result_ready / result): exactly one result
// per input transfer, in order: winner after the sample, correct count,
// longest run (current run included) and current run.
// A result goes through the input register, then the result register, before
// it can transfer. Throughput: one item per cycle while result_ready stays
// high; scoring, the run update and the ordered winner select all sit in the
// single logic stage between the two registers, which carries the state
// loop.
// Reset (rst, synchronous) empties both registers and clears scores, winner
// and counters. When the receiver stalls, the result register holds its
// transfer, the input register may still take one more item, and then
// item_ready drops until result_ready returns.
// Counters and scores saturate at all ones of COUNT_WIDTH bits; the result
// fields carry the low 24 bits.
`include "assert_macros.svh"

module predictor_scoreboard_tracker #(
  parameter int NUM_PREDICTORS = pst_pkg::NUM_PREDICTORS_DEF,
  parameter int COUNT_WIDTH = pst_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pst_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output pst_pkg::out_item_t result
);

  // input register
  logic              s1_valid;
  pst_pkg::in_item_t s1;

  // tracker state
  logic [COUNT_WIDTH-1:0]    scores [NUM_PREDICTORS];
  logic [pst_pkg::WIN_W-1:0] winner;
  logic [COUNT_WIDTH-1:0]    correct_total;
  logic [COUNT_WIDTH-1:0]    run_length;
  logic [COUNT_WIDTH-1:0]    best_run;

  // next state
  logic [COUNT_WIDTH-1:0]    scores_eff [NUM_PREDICTORS];
  logic [COUNT_WIDTH-1:0]    scores_next [NUM_PREDICTORS];
  logic [pst_pkg::WIN_W-1:0] winner_eff;
  logic [pst_pkg::WIN_W-1:0] winner_next;
  logic [COUNT_WIDTH-1:0]    correct_eff, run_eff, best_eff;
  logic [COUNT_WIDTH-1:0]    correct_total_next, run_length_next, best_run_next;
  logic [COUNT_WIDTH-1:0]    longest;
  logic [pst_pkg::MAX_CNT_W-1:0] correct_wide, longest_wide, run_wide;

  logic [pst_pkg::SYM_W-1:0]     pred [pst_pkg::MAX_PRED];
  logic [NUM_PREDICTORS-1:0]     match;
  logic                          hit;
  logic                          advance;
  pst_pkg::out_item_t            result_next;

  // Move the stage forward when the result register is free or being drained.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1 <= item;
    end
  end

  // Unpack the predictions so they can be indexed by the winner.
  always_comb begin
    pred[0] = s1.pred_0;
    pred[1] = s1.pred_1;
    pred[2] = s1.pred_2;
    pred[3] = s1.pred_3;
    pred[4] = s1.pred_4;
    pred[5] = s1.pred_5;
    pred[6] = s1.pred_6;
    pred[7] = s1.pred_7;
  end

  // Apply the first-sample clear ahead of scoring.
  always_comb begin
    for (int i = 0; i < NUM_PREDICTORS; i++) begin
      scores_eff[i] = s1.first_sample ? '0 : scores[i];
      match[i]      = pred[i] == s1.sample;
    end
    winner_eff  = s1.first_sample ? '0 : winner;
    correct_eff = s1.first_sample ? '0 : correct_total;
    run_eff     = s1.first_sample ? '0 : run_length;
    best_eff    = s1.first_sample ? '0 : best_run;
  end

  // Check the winner's call: a hit extends the run, a miss folds it into best.
  assign hit = pred[winner_eff] == s1.sample;

  always_comb begin
    if (hit) begin
      run_length_next    = (run_eff == '1) ? run_eff : run_eff + 1'b1;
      correct_total_next = (correct_eff == '1) ? correct_eff : correct_eff + 1'b1;
      best_run_next      = best_eff;
    end else begin
      run_length_next    = '0;
      correct_total_next = correct_eff;
      best_run_next      = (best_eff < run_eff) ? run_eff : best_eff;
    end
    longest = (best_run_next > run_length_next) ? best_run_next : run_length_next;
  end

  pst_winner_sel #(
    .NUM_PREDICTORS(NUM_PREDICTORS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_winner_sel (
    .match      (match),
    .scores     (scores_eff),
    .winner     (winner_eff),
    .scores_next(scores_next),
    .winner_next(winner_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PREDICTORS; i++) begin
        scores[i] <= '0;
      end
      winner        <= '0;
      correct_total <= '0;
      run_length    <= '0;
      best_run      <= '0;
    end else if (advance) begin
      scores        <= scores_next;
      winner        <= winner_next;
      correct_total <= correct_total_next;
      run_length    <= run_length_next;
      best_run      <= best_run_next;
    end
  end

  // Bring counters to the 24-bit result fields.
  always_comb begin
    correct_wide               = pst_pkg::MAX_CNT_W'(correct_total_next);
    longest_wide               = pst_pkg::MAX_CNT_W'(longest);
    run_wide                   = pst_pkg::MAX_CNT_W'(run_length_next);
    result_next.winner_index  = winner_next;
    result_next.correct_count = correct_wide[pst_pkg::OUT_CNT_W-1:0];
    result_next.longest_run   = longest_wide[pst_pkg::OUT_CNT_W-1:0];
    result_next.current_run   = run_wide[pst_pkg::OUT_CNT_W-1:0];
    result_next.done_res      = s1.last_sample;
  end

  // Result register: load on advance, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `PST_ASSERT_RST(a_winner_range, clk, rst, int'(winner) < NUM_PREDICTORS, "winner out of range")
  `PST_ASSERT_RST(a_run_le_correct, clk, rst, run_length <= correct_total, "run above correct count")
  `PST_ASSERT_RST(a_advance_loads, clk, rst, advance |=> result_valid, "no result after advance")
  `PST_ASSERT(a_stall_holds_input, clk, !item_ready |-> s1_valid, "input stalled while empty")

endmodule
